>>> sv/packed_pixel_framebuffer_core_defines.svh
// ----------------------------------------------------------------------------
// packed pixel frame buffer assertion macros
// shared helpers for concurrent checks clocked on the block clock
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_FRAMEBUFFER_CORE_DEFINES_SVH
`define PACKED_PIXEL_FRAMEBUFFER_CORE_DEFINES_SVH

// same-cycle implication
`define PPFB_ASSERT_COMB(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ppfb_pkg.sv
// ----------------------------------------------------------------------------
// ppfb_pkg
// shared types, codes and constants of the packed pixel frame buffer
// ----------------------------------------------------------------------------
package ppfb_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int PADDR_W = 4;
  localparam int X_W     = 8;
  localparam int Y_W     = 7;

  localparam logic [31:0] HALF_MASK  = 32'h0000_ffff;
  localparam int unsigned HALF_SHIFT = 16;

  localparam logic [1:0] RST_COLOR_MODE   = 2'd0;
  localparam logic [7:0] RST_FRAME_WIDTH  = 8'd128;
  localparam logic [6:0] RST_FRAME_HEIGHT = 7'd64;

  typedef enum logic [1:0] {
    REG_COLOR_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    MODE_MONO   = 2'd0,
    MODE_RGB565 = 2'd1,
    MODE_ARGB   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RESULT = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] color_mode;
    logic [7:0] frame_width;
    logic [6:0] frame_height;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic        status;
    logic [4:0]  shift;
    logic [31:0] rmask;
    logic        overwrite;
    logic [31:0] wdata;
  } req_t;

endpackage

>>> sv/ppfb_front.sv
// ----------------------------------------------------------------------------
// ppfb_front
// accepts requests, checks bounds and works out word address and bit lanes
// ----------------------------------------------------------------------------
module ppfb_front #(
  parameter int MAX_WIDTH = ppfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ppfb_pkg::DEF_MAX_HEIGHT,
  parameter int AW = 13
) (
  input  ppfb_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [15:0] pixel_x_i,
  input  logic signed [15:0] pixel_y_i,
  input  logic [31:0]        pixel_value_i,
  input  logic               q_full_i,
  input  logic               init_busy_i,
  output logic               push_o,
  output ppfb_pkg::req_t     req_o,
  output logic [AW-1:0]      addr_o
);

  logic [15:0] w_eff;
  logic [15:0] h_eff;
  logic        oob;
  logic [ppfb_pkg::X_W-1:0] ux;
  logic [ppfb_pkg::X_W-1:0] wm1;
  logic [ppfb_pkg::X_W-1:0] col;
  logic [ppfb_pkg::Y_W-1:0] uy;
  logic        mode_ok;

  assign in_stall_o = q_full_i || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign w_eff = (16'(cfg_i.frame_width) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH)
                                                          : 16'(cfg_i.frame_width);
  assign h_eff = (16'(cfg_i.frame_height) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT)
                                                            : 16'(cfg_i.frame_height);

  assign oob = pixel_x_i[15] || pixel_y_i[15] ||
               ($unsigned(pixel_x_i) >= w_eff) || ($unsigned(pixel_y_i) >= h_eff);

  assign ux  = pixel_x_i[ppfb_pkg::X_W-1:0];
  assign uy  = pixel_y_i[ppfb_pkg::Y_W-1:0];
  assign wm1 = w_eff[ppfb_pkg::X_W-1:0] - 8'd1;

  always_comb begin
    mode_ok         = 1'b1;
    col             = '0;
    req_o.op        = ppfb_pkg::OP_RESULT;
    req_o.status    = 1'b0;
    req_o.shift     = '0;
    req_o.rmask     = '0;
    req_o.overwrite = 1'b0;
    req_o.wdata     = '0;
    unique case (cfg_i.color_mode)
      ppfb_pkg::MODE_MONO: begin
        col         = (wm1 >> 5) - (ux >> 5);
        req_o.shift = ~ux[4:0];
        req_o.rmask = 32'h1;
        req_o.wdata = 32'(pixel_value_i[0]) << req_o.shift;
      end
      ppfb_pkg::MODE_RGB565: begin
        col         = (wm1 >> 1) - (ux >> 1);
        req_o.shift = ux[0] ? 5'd0 : 5'(ppfb_pkg::HALF_SHIFT);
        req_o.rmask = ppfb_pkg::HALF_MASK;
        req_o.wdata = (pixel_value_i & ppfb_pkg::HALF_MASK) << req_o.shift;
      end
      ppfb_pkg::MODE_ARGB: begin
        col             = wm1 - ux;
        req_o.rmask     = '1;
        req_o.overwrite = 1'b1;
        req_o.wdata     = pixel_value_i;
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase

    unique case (action_i)
      ppfb_pkg::ACT_READ, ppfb_pkg::ACT_WRITE: begin
        if (oob) begin
          req_o.status = 1'b1;
        end else if (mode_ok) begin
          if (action_i == ppfb_pkg::ACT_WRITE) begin
            req_o.op = ppfb_pkg::OP_WRITE;
          end else begin
            req_o.op = ppfb_pkg::OP_READ;
          end
        end
      end
      ppfb_pkg::ACT_CLEAR: begin
        req_o.op = ppfb_pkg::OP_CLEAR;
      end
      default: begin
        req_o.op = ppfb_pkg::OP_RESULT;
      end
    endcase
  end

  assign addr_o = AW'(32'(uy) * MAX_WIDTH) + AW'(col);

endmodule

>>> sv/ppfb_queue.sv
// ----------------------------------------------------------------------------
// ppfb_queue
// two-entry request queue between the front and the back
// ----------------------------------------------------------------------------
module ppfb_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] slot_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;
  logic [1:0]        count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/ppfb_back.sv
// ----------------------------------------------------------------------------
// ppfb_back
// pixel store, read-modify-write of one word, clear sweep and result register
// ----------------------------------------------------------------------------
module ppfb_back #(
  parameter int MAX_WIDTH = ppfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ppfb_pkg::DEF_MAX_HEIGHT,
  parameter int AW = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ppfb_pkg::req_t q_req_i,
  input  logic [AW-1:0]  q_addr_i,
  output logic           q_pop_o,
  output logic           init_busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    read_value_o,
  output logic           status_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACCESS,
    ST_CLEAR,
    ST_CLEAR_DONE
  } state_e;

  state_e         state_q;
  logic [AW-1:0]  clr_cnt_q;
  ppfb_pkg::req_t cur_q;
  logic [AW-1:0]  cur_addr_q;
  logic           out_valid_q;
  logic [31:0]    read_value_q;
  logic           status_q;

  logic [31:0]    store_q [DEPTH];
  logic [31:0]    mem_rdata_q;

  logic           out_free;
  logic           clr_last;
  logic           mem_re;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic [31:0]    merged;
  logic [31:0]    rd_pixel;
  logic           load_out;
  logic [31:0]    load_value;
  logic           load_status;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign clr_last    = clr_cnt_q == AW'(DEPTH - 1);
  assign merged      = cur_q.overwrite ? cur_q.wdata : (mem_rdata_q | cur_q.wdata);
  assign rd_pixel    = (mem_rdata_q >> cur_q.shift) & cur_q.rmask;
  assign init_busy_o = state_q == ST_INIT;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;

  always_comb begin
    q_pop_o     = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_addr_q;
    mem_wdata   = merged;
    load_out    = 1'b0;
    load_value  = '0;
    load_status = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_req_i.op == ppfb_pkg::OP_RESULT) begin
            if (out_free) begin
              q_pop_o     = 1'b1;
              load_out    = 1'b1;
              load_status = q_req_i.status;
            end
          end else begin
            q_pop_o = 1'b1;
            mem_re  = q_req_i.op != ppfb_pkg::OP_CLEAR;
          end
        end
      end
      ST_ACCESS: begin
        if (out_free) begin
          load_out = 1'b1;
          if (cur_q.op == ppfb_pkg::OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            load_value = rd_pixel;
          end
        end
      end
      ST_CLEAR_DONE: begin
        load_out = out_free;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      clr_cnt_q    <= '0;
      cur_q        <= '0;
      cur_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      read_value_q <= '0;
      status_q     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q  <= 1'b1;
        read_value_q <= load_value;
        status_q     <= load_status;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_INIT: begin
          if (clr_last) begin
            clr_cnt_q <= '0;
            state_q   <= ST_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (q_pop_o && q_req_i.op != ppfb_pkg::OP_RESULT) begin
            cur_q      <= q_req_i;
            cur_addr_q <= q_addr_i;
            state_q    <= (q_req_i.op == ppfb_pkg::OP_CLEAR) ? ST_CLEAR : ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          if (clr_last) begin
            clr_cnt_q <= '0;
            state_q   <= ST_CLEAR_DONE;
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end
        ST_CLEAR_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= store_q[q_addr_i];
    end
  end

endmodule

>>> sv/packed_pixel_framebuffer_core.sv
// ----------------------------------------------------------------------------
// packed_pixel_framebuffer_core
// packed pixel frame buffer with mono, rgb565 and argb modes
// ----------------------------------------------------------------------------
// requests come in on the in channel (action, pixel_x, pixel_y, pixel_value)
// and each one gives exactly one response on the out channel (read_value,
// status), in request order. an item moves when valid is high and stall low.
// mode and geometry sit in three registers on the apb port; the user must
// write them only while idle, and the block itself does not enforce this.
// a read or write does one memory read, then a result load, plus a memory
// write for a write; the back end takes no new request until it is done.
// out-of-bounds and no-op requests are answered straight from idle. a
// clear request sweeps all MAX_WIDTH*MAX_HEIGHT store words one word per
// cycle, then answers. after reset the same sweep runs with in_stall_o
// high; apb writes still work. a two-entry queue lets requests come in
// while the back end is busy; when the receiver stalls, the response
// register holds and the queue fills up, then in_stall_o rises.
// ----------------------------------------------------------------------------
module packed_pixel_framebuffer_core #(
  parameter int MAX_WIDTH = ppfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ppfb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppfb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic signed [15:0]           pixel_x_i,
  input  logic signed [15:0]           pixel_y_i,
  input  logic [31:0]                  pixel_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  read_value_o,
  output logic                         status_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int REQ_W  = $bits(ppfb_pkg::req_t);
  localparam int DATA_W = AW + REQ_W;

  ppfb_pkg::cfg_t cfg_q;
  logic           cfg_we;
  logic [1:0]     reg_idx;

  logic           push;
  ppfb_pkg::req_t front_req;
  logic [AW-1:0]  front_addr;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic [DATA_W-1:0] q_rdata;
  ppfb_pkg::req_t back_req;
  logic [AW-1:0]  back_addr;
  logic           init_busy;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode   <= ppfb_pkg::RST_COLOR_MODE;
      cfg_q.frame_width  <= ppfb_pkg::RST_FRAME_WIDTH;
      cfg_q.frame_height <= ppfb_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (reg_idx)
        ppfb_pkg::REG_COLOR_MODE:   cfg_q.color_mode   <= pwdata[1:0];
        ppfb_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[7:0];
        ppfb_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[6:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ppfb_pkg::REG_COLOR_MODE:   prdata = 32'(cfg_q.color_mode);
      ppfb_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
      ppfb_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
      default:                    prdata = '0;
    endcase
  end

  ppfb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .pixel_value_i (pixel_value_i),
    .q_full_i      (q_full),
    .init_busy_i   (init_busy),
    .push_o        (push),
    .req_o         (front_req),
    .addr_o        (front_addr)
  );

  ppfb_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_addr, front_req}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign back_addr = q_rdata[DATA_W-1:REQ_W];
  assign back_req  = ppfb_pkg::req_t'(q_rdata[REQ_W-1:0]);

  ppfb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_req_i      (back_req),
    .q_addr_i     (back_addr),
    .q_pop_o      (q_pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

endmodule

>>> sv/ppfb_port_checker.sv
// ----------------------------------------------------------------------------
// ppfb_port_checker
// port-level checks of the packed pixel frame buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "packed_pixel_framebuffer_core_defines.svh"

module ppfb_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [31:0] read_value_i,
  input logic        status_i
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_i;
  assign out_acc = out_valid_i && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  // a stalled response holds
  `PPFB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(read_value_i) && $stable(status_i), "response changed while stalled")

  // out-of-bounds responses carry no pixel
  `PPFB_ASSERT_COMB(a_oob_zero, clk_i, rst_ni, out_valid_i && status_i, read_value_i == 32'd0, "out-of-bounds response with nonzero value")

  // the clearing sweep blocks requests right after reset
  `PPFB_ASSERT_COMB(a_init_stall, clk_i, rst_ni, !$past(rst_ni), in_stall_i, "request taken during clearing sweep")

  // no response without an outstanding request
  `PPFB_ASSERT_COMB(a_no_extra, clk_i, rst_ni, out_valid_i, pending_q != 3'd0, "response without a request")

endmodule

bind packed_pixel_framebuffer_core ppfb_port_checker u_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_i (read_value_o),
  .status_i     (status_o)
);

>>> dv/tb_packed_pixel_framebuffer_core.sv
// ----------------------------------------------------------------------------
// tb_packed_pixel_framebuffer_core
// self-checking testbench of the packed pixel frame buffer: a local model of
// the packed store predicts every response, requests go in bursts with random
// gaps, the receiver stalls in runs and once holds off long enough to fill
// the block, and the geometry and colour mode walk through several settings
// ----------------------------------------------------------------------------
module tb_packed_pixel_framebuffer_core;

  localparam int          FB_WIDTH     = ppfb_pkg::DEF_MAX_WIDTH;
  localparam int          FB_HEIGHT    = ppfb_pkg::DEF_MAX_HEIGHT;
  localparam int          FB_WORDS     = FB_WIDTH * FB_HEIGHT;
  localparam int          PADDR_W      = ppfb_pkg::PADDR_W;
  localparam logic [1:0]  ACT_NOP      = 2'd3;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int unsigned IDLE_LIMIT   = 40000;
  localparam int          RECENT_DEPTH = 32;

  typedef struct packed {
    logic [31:0] read_value;
    logic        status;
  } pixel_resp_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pixel_coord_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            action_i;
  logic signed [15:0]    pixel_x_i;
  logic signed [15:0]    pixel_y_i;
  logic [31:0]           pixel_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [31:0]           read_value_o;
  logic                  status_o;

  logic [31:0]           fb_words [FB_WORDS];
  logic [1:0]            cfg_mode;
  logic [7:0]            cfg_width;
  logic [6:0]            cfg_height;

  pixel_resp_t           pending_results [$];
  pixel_coord_t          recent_writes [$];
  int unsigned           error_count;
  int unsigned           idle_cycles;
  int unsigned           tx_burst_left;
  bit                    tx_gaps_on;
  bit                    rx_stall_on;
  int unsigned           rx_hold_left;

  packed_pixel_framebuffer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic pixel_resp_t compute_pixel_response(input logic [1:0] act,
                                                         input logic signed [15:0] px,
                                                         input logic signed [15:0] py,
                                                         input logic [31:0] val);
    pixel_resp_t resp;
    int          w;
    int          h;
    int          sx;
    int          sy;
    int          ppw;
    int          wpr;
    int          idx;
    int          shift;
    logic [31:0] word;
    resp = '0;
    w = (cfg_width > FB_WIDTH) ? FB_WIDTH : int'(cfg_width);
    h = (cfg_height > FB_HEIGHT) ? FB_HEIGHT : int'(cfg_height);
    sx = px;
    sy = py;
    if (act == ppfb_pkg::ACT_CLEAR) begin
      foreach (fb_words[i]) fb_words[i] = '0;
      return resp;
    end
    if (act == ACT_NOP) return resp;
    if (sx < 0 || sy < 0 || sx >= w || sy >= h) begin
      resp.status = 1'b1;
      return resp;
    end
    case (cfg_mode)
      ppfb_pkg::MODE_MONO:   ppw = 32;
      ppfb_pkg::MODE_RGB565: ppw = 2;
      default:               ppw = 1;
    endcase
    wpr = 1 + (w - 1) / ppw;
    idx = sy * FB_WIDTH + (wpr - 1 - sx / ppw);
    word = fb_words[idx];
    case (cfg_mode)
      ppfb_pkg::MODE_MONO: begin
        shift = 31 - (sx & 31);
        if (act == ppfb_pkg::ACT_WRITE) fb_words[idx] = word | ((val & 32'd1) << shift);
        else resp.read_value = (word >> shift) & 32'd1;
      end
      ppfb_pkg::MODE_RGB565: begin
        shift = (sx & 1) ? 0 : int'(ppfb_pkg::HALF_SHIFT);
        if (act == ppfb_pkg::ACT_WRITE) begin
          fb_words[idx] = word | ((val & ppfb_pkg::HALF_MASK) << shift);
        end else begin
          resp.read_value = (word >> shift) & ppfb_pkg::HALF_MASK;
        end
      end
      ppfb_pkg::MODE_ARGB: begin
        if (act == ppfb_pkg::ACT_WRITE) fb_words[idx] = val;
        else resp.read_value = word;
      end
      default: ;
    endcase
    return resp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // response check, request prediction and watchdog
  always @(posedge clk_i) begin : monitor
    pixel_resp_t want;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("response with nothing pending", read_value_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (read_value_o !== want.read_value)
            report_mismatch("read_value", read_value_o, want.read_value);
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        pending_results.push_back(compute_pixel_response(action_i, pixel_x_i,
                                                         pixel_y_i, pixel_value_i));
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", idle_cycles);
        $display("packed_pixel_framebuffer_core regression: fail");
        $finish;
      end
    end
  end

  // receiver: runs of stall and accept, plus a long hold-off on request
  initial begin : receiver
    bit          stall_run;
    int unsigned run_left;
    stall_run = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_stall_i = 1'b1;
        rx_hold_left--;
      end else if (!rx_stall_on) begin
        out_stall_i = 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_run = ~stall_run;
          run_left = stall_run ? $urandom_range(1, 4) : $urandom_range(1, 10);
        end
        out_stall_i = stall_run;
        run_left--;
      end
    end
  end

  task automatic send_pixel_request(input logic [1:0] act, input logic signed [15:0] px,
                                    input logic signed [15:0] py, input logic [31:0] val);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 12);
      gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    tx_burst_left--;
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    action_i      = act;
    pixel_x_i     = px;
    pixel_y_i     = py;
    pixel_value_i = val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_for_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input ppfb_pkg::reg_e which, input logic [31:0] value);
    wait_for_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(which) << 2;
    pwdata  = $urandom;
    case (which)
      ppfb_pkg::REG_COLOR_MODE:  pwdata[1:0] = value[1:0];
      ppfb_pkg::REG_FRAME_WIDTH: pwdata[7:0] = value[7:0];
      default:                   pwdata[6:0] = value[6:0];
    endcase
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (which)
      ppfb_pkg::REG_COLOR_MODE:  cfg_mode   = value[1:0];
      ppfb_pkg::REG_FRAME_WIDTH: cfg_width  = value[7:0];
      default:                   cfg_height = value[6:0];
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_geometry(input logic [1:0] mode, input logic [7:0] w,
                              input logic [6:0] h);
    write_config(ppfb_pkg::REG_COLOR_MODE, 32'(mode));
    write_config(ppfb_pkg::REG_FRAME_WIDTH, 32'(w));
    write_config(ppfb_pkg::REG_FRAME_HEIGHT, 32'(h));
  endtask

  function automatic logic signed [15:0] pick_coord(input int eff, input int raw);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80 && eff > 0) return 16'($urandom_range(0, eff - 1));
    if (r < 85) return -16'sd1;
    if (r < 90) return 16'(eff);
    if (r < 93) return 16'(raw);
    return 16'($urandom);
  endfunction

  task automatic send_random_pixel();
    int unsigned        r;
    int                 w;
    int                 h;
    logic [1:0]         act;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [31:0]        val;
    pixel_coord_t       spot;
    w = (cfg_width > FB_WIDTH) ? FB_WIDTH : int'(cfg_width);
    h = (cfg_height > FB_HEIGHT) ? FB_HEIGHT : int'(cfg_height);
    r = $urandom_range(0, 199);
    if (r < 2) act = ppfb_pkg::ACT_CLEAR;
    else if (r < 10) act = ACT_NOP;
    else if (r < 100) act = ppfb_pkg::ACT_WRITE;
    else act = ppfb_pkg::ACT_READ;
    px = pick_coord(w, int'(cfg_width));
    py = pick_coord(h, int'(cfg_height));
    if (act == ppfb_pkg::ACT_READ && recent_writes.size() != 0 && $urandom_range(0, 1)) begin
      spot = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
      px = spot.x;
      py = spot.y;
    end
    val = $urandom;
    if (act == ppfb_pkg::ACT_WRITE) begin
      recent_writes.push_back('{x: px, y: py});
      if (recent_writes.size() > RECENT_DEPTH) void'(recent_writes.pop_front());
    end
    send_pixel_request(act, px, py, val);
  endtask

  task automatic test_reset_state();
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd0, 16'sd0, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd0, 16'sd0, 32'hffff_ffff);
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd127, 16'sd63, 32'h0000_0001);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd0, 16'sd0, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd127, 16'sd63, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd1, 16'sd0, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_WRITE, -16'sd32768, 16'sd32767, 32'hffff_ffff);
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd32767, -16'sd1, 32'hffff_ffff);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd128, 16'sd0, 32'h0);
    send_pixel_request(ACT_NOP, -16'sd1, 16'sd64, 32'hffff_ffff);
    send_pixel_request(ppfb_pkg::ACT_CLEAR, 16'sd5, 16'sd5, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd0, 16'sd0, 32'h0);
  endtask

  task automatic test_color_modes();
    set_geometry(ppfb_pkg::MODE_RGB565, 8'd128, 7'd64);
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd4, 16'sd2, 32'habcd_1234);
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd5, 16'sd2, 32'hffff_ffff);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd4, 16'sd2, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd5, 16'sd2, 32'h0);
    set_geometry(ppfb_pkg::MODE_ARGB, 8'd128, 7'd64);
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd127, 16'sd63, 32'hdead_beef);
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd127, 16'sd63, 32'h0000_0001);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd127, 16'sd63, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd66, 16'sd2, 32'h0);
    write_config(ppfb_pkg::REG_COLOR_MODE, 32'(MODE_UNUSED));
    send_pixel_request(ppfb_pkg::ACT_WRITE, 16'sd0, 16'sd0, 32'hffff_ffff);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd0, 16'sd0, 32'h0);
  endtask

  task automatic test_odd_geometry();
    set_geometry(ppfb_pkg::MODE_ARGB, 8'd0, 7'd64);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd0, 16'sd0, 32'h0);
    set_geometry(ppfb_pkg::MODE_ARGB, 8'd255, 7'd127);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd127, 16'sd63, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd128, 16'sd0, 32'h0);
    send_pixel_request(ppfb_pkg::ACT_READ, 16'sd0, 16'sd64, 32'h0);
  endtask

  task automatic test_random_phases();
    logic [1:0] phase_mode [9] = '{ppfb_pkg::MODE_MONO, ppfb_pkg::MODE_RGB565,
                                   ppfb_pkg::MODE_ARGB, ppfb_pkg::MODE_MONO,
                                   ppfb_pkg::MODE_RGB565, ppfb_pkg::MODE_ARGB,
                                   MODE_UNUSED, ppfb_pkg::MODE_MONO,
                                   ppfb_pkg::MODE_RGB565};
    logic [7:0] phase_width [9] = '{8'd128, 8'd128, 8'd128, 8'd255, 8'd37, 8'd1,
                                    8'd128, 8'd0, 8'd64};
    logic [6:0] phase_height [9] = '{7'd64, 7'd64, 7'd64, 7'd127, 7'd5, 7'd1,
                                     7'd64, 7'd64, 7'd0};
    int         count;
    for (int p = 0; p < 9; p++) begin
      set_geometry(phase_mode[p], phase_width[p], phase_height[p]);
      recent_writes.delete();
      tx_gaps_on  = (p % 3) != 2;
      rx_stall_on = (p % 4) != 3;
      count = (phase_width[p] == 0 || phase_height[p] == 0) ? 40 : 105;
      repeat (count) send_random_pixel();
    end
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_geometry(ppfb_pkg::MODE_RGB565, 8'd128, 7'd64);
    tx_gaps_on = 1'b0;
    rx_hold_left = 400;
    repeat (32) send_random_pixel();
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    action_i      = ppfb_pkg::ACT_READ;
    pixel_x_i     = '0;
    pixel_y_i     = '0;
    pixel_value_i = '0;
    out_stall_i   = 1'b0;
    error_count   = 0;
    idle_cycles   = 0;
    tx_burst_left = 0;
    tx_gaps_on    = 1'b1;
    rx_stall_on   = 1'b1;
    rx_hold_left  = 0;
    foreach (fb_words[i]) fb_words[i] = '0;
    cfg_mode   = ppfb_pkg::RST_COLOR_MODE;
    cfg_width  = ppfb_pkg::RST_FRAME_WIDTH;
    cfg_height = ppfb_pkg::RST_FRAME_HEIGHT;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_color_modes();
    test_odd_geometry();
    test_random_phases();
    test_backpressure();

    wait_for_idle();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("responses missing", '0, 32'(pending_results.size()));
    if (error_count == 0) begin
      $display("packed_pixel_framebuffer_core regression: pass");
    end else begin
      $display("packed_pixel_framebuffer_core regression: fail");
    end
    $finish;
  end

endmodule
